// File: sv/fbpa_pkg.sv
// Shared types and codes of the fixed block pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;

  localparam int NUM_POOLS = 3;
  localparam int POOL_W    = 2;
  localparam int SIZE_W    = 16;
  localparam int ADDR_W    = 32;
  localparam int HDR_W     = 4;
  localparam int STAT_W    = 3;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  typedef logic [POOL_W-1:0] pool_t;

  localparam pool_t POOL0 = 2'd0;
  localparam pool_t POOL1 = 2'd1;
  localparam pool_t POOL2 = 2'd2;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_EXHAUSTED    = 3'd1,
    STAT_NO_FIT       = 3'd2,
    STAT_BAD_ADDR     = 3'd3,
    STAT_ALREADY_FREE = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    REG_AREA_BASE    = 1'b0,
    REG_HEADER_BYTES = 1'b1
  } reg_index_t;

  localparam logic [HDR_W-1:0] HEADER_RESET = 4'd8;

endpackage
`default_nettype wire

// File: sv/fixed_block_pool_allocator.sv
// Fixed block pool allocator: three LIFO free lists kept in one link RAM.
// A beat is decoded in S_CALC; the link RAM is read in S_INDEX (registered read data) and written
// in S_UPDATE, which answers once the output is free. No new beat is taken until that answer.
// After reset the block writes the address-order chains of all TOTAL_BLOCKS (20 by default)
// link RAM entries and takes no request beat meanwhile; configuration writes are taken.
// Reset is synchronous and active high; it restores both registers and all free lists.
`timescale 1ns / 1ps
`default_nettype none
module fixed_block_pool_allocator #(
  parameter int unsigned POOL0_BYTES = 16,
  parameter int unsigned POOL0_COUNT = 8,
  parameter int unsigned POOL1_BYTES = 32,
  parameter int unsigned POOL1_COUNT = 8,
  parameter int unsigned POOL2_BYTES = 64,
  parameter int unsigned POOL2_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // request_size [15:0], block_address [47:16]
  input  logic [fbpa_pkg::S_TDATA_W-1:0] s_tdata,
  // command [0]
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // payload_address [31:0], pool_index [33:32], status [36:34], zero fill [39:37]
  output logic [fbpa_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

  import fbpa_pkg::*;

  localparam int unsigned TOTAL_BLOCKS = POOL0_COUNT + POOL1_COUNT + POOL2_COUNT;
  localparam int BLK_W  = $clog2(TOTAL_BLOCKS);
  localparam int WORD_W = BLK_W + 1;

  localparam int unsigned FIRST1 = POOL0_COUNT;
  localparam int unsigned FIRST2 = POOL0_COUNT + POOL1_COUNT;

  localparam int unsigned SPAN0 = POOL0_BYTES * POOL0_COUNT;
  localparam int unsigned SPAN1 = POOL1_BYTES * POOL1_COUNT;
  localparam int unsigned SPAN2 = POOL2_BYTES * POOL2_COUNT;
  localparam int unsigned SPAN01 = (SPAN0 > SPAN1) ? SPAN0 : SPAN1;
  localparam int unsigned SPAN_MAX = (SPAN01 > SPAN2) ? SPAN01 : SPAN2;

  localparam logic [ADDR_W-1:0] OFF0 = '0;
  localparam logic [ADDR_W-1:0] OFF1 = ADDR_W'(SPAN0);
  localparam logic [ADDR_W-1:0] OFF2 = ADDR_W'(SPAN0 + SPAN1);

  localparam int unsigned CNT01 = (POOL0_COUNT > POOL1_COUNT) ? POOL0_COUNT : POOL1_COUNT;
  localparam int unsigned MAX_COUNT = (CNT01 > POOL2_COUNT) ? CNT01 : POOL2_COUNT;
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int LOC_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

  localparam int REL_W  = $clog2(SPAN_MAX + 1);
  localparam int REC_W  = REL_W + 1;
  localparam int PROD_W = REL_W + REC_W;

  localparam int SH0 = REL_W + $clog2(POOL0_BYTES);
  localparam int SH1 = REL_W + $clog2(POOL1_BYTES);
  localparam int SH2 = REL_W + $clog2(POOL2_BYTES);

  localparam logic [63:0] RECIP0_64 =
    ((64'd1 << SH0) + 64'(POOL0_BYTES) - 64'd1) / 64'(POOL0_BYTES);
  localparam logic [63:0] RECIP1_64 =
    ((64'd1 << SH1) + 64'(POOL1_BYTES) - 64'd1) / 64'(POOL1_BYTES);
  localparam logic [63:0] RECIP2_64 =
    ((64'd1 << SH2) + 64'(POOL2_BYTES) - 64'd1) / 64'(POOL2_BYTES);
  localparam logic [REC_W-1:0] RECIP0 = RECIP0_64[REC_W-1:0];
  localparam logic [REC_W-1:0] RECIP1 = RECIP1_64[REC_W-1:0];
  localparam logic [REC_W-1:0] RECIP2 = RECIP2_64[REC_W-1:0];

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_CALC   = 5'b00100,
    S_INDEX  = 5'b01000,
    S_UPDATE = 5'b10000
  } state_t;

  function automatic logic [BLK_W-1:0] first_of(input pool_t p);
    case (p)
      POOL1:   first_of = BLK_W'(FIRST1);
      POOL2:   first_of = BLK_W'(FIRST2);
      default: first_of = '0;
    endcase
  endfunction

  function automatic logic [REL_W-1:0] bytes_of(input pool_t p);
    case (p)
      POOL1:   bytes_of = REL_W'(POOL1_BYTES);
      POOL2:   bytes_of = REL_W'(POOL2_BYTES);
      default: bytes_of = REL_W'(POOL0_BYTES);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] off_of(input pool_t p);
    case (p)
      POOL1:   off_of = OFF1;
      POOL2:   off_of = OFF2;
      default: off_of = OFF0;
    endcase
  endfunction

  function automatic logic [REC_W-1:0] recip_of(input pool_t p);
    case (p)
      POOL1:   recip_of = RECIP1;
      POOL2:   recip_of = RECIP2;
      default: recip_of = RECIP0;
    endcase
  endfunction

  function automatic logic [LOC_W-1:0] quot_of(input logic [PROD_W-1:0] pr, input pool_t p);
    logic [PROD_W-1:0] sh;
    case (p)
      POOL1:   sh = pr >> SH1;
      POOL2:   sh = pr >> SH2;
      default: sh = pr >> SH0;
    endcase
    quot_of = sh[LOC_W-1:0];
  endfunction

  state_t               state;
  logic [BLK_W-1:0]     init_ptr;
  logic [ADDR_W-1:0]    area_base;
  logic [HDR_W-1:0]     header_bytes;

  cmd_t                 cmd;
  logic [SIZE_W-1:0]    req_size;
  logic [ADDR_W-1:0]    req_addr;

  pool_t                pool;
  logic                 hit;
  logic                 exhausted;
  logic [BLK_W-1:0]     blk;
  logic [REL_W-1:0]     rel;
  logic [PROD_W-1:0]    prod;
  logic [REL_W-1:0]     blk_off;
  logic                 aligned;

  logic [BLK_W-1:0]     heads  [NUM_POOLS];
  logic [CNT_W-1:0]     counts [NUM_POOLS];

  logic [ADDR_W-1:0]    out_addr;
  pool_t                out_pool;
  status_t              out_status;

  logic [SIZE_W:0]      need;
  logic                 fit0, fit1, fit2;
  logic                 in0, in1, in2;
  logic [ADDR_W-1:0]    off;
  logic [ADDR_W-1:0]    diff;
  pool_t                alloc_pool, free_pool;
  logic                 alloc_fit, free_hit;
  logic [REL_W-1:0]     rel_calc;

  logic [LOC_W-1:0]     quot;
  logic [BLK_W-1:0]     loc_diff;
  logic [LOC_W-1:0]     mul_in;
  logic [REL_W-1:0]     prod2;
  logic [BLK_W-1:0]     free_blk;

  logic [BLK_W-1:0]     init_link;
  logic                 out_free;
  logic                 ram_wr_en;
  logic [BLK_W-1:0]     ram_wr_addr;
  logic [WORD_W-1:0]    ram_wr_data;
  logic                 ram_rd_en;
  logic [BLK_W-1:0]     ram_rd_addr;
  logic [WORD_W-1:0]    ram_rd_data;
  logic                 rd_in_use;
  logic [BLK_W-1:0]     rd_link;
  logic                 alloc_ok, free_ok;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, out_status, out_pool, out_addr};

  // Request decode: first fitting pool for allocate, owning pool for free.
  always_comb begin
    need = (SIZE_W + 1)'(req_size) + (SIZE_W + 1)'(header_bytes);
    fit0 = ADDR_W'(need) <= ADDR_W'(POOL0_BYTES);
    fit1 = ADDR_W'(need) <= ADDR_W'(POOL1_BYTES);
    fit2 = ADDR_W'(need) <= ADDR_W'(POOL2_BYTES);
    alloc_fit  = fit0 | fit1 | fit2;
    alloc_pool = fit0 ? POOL0 : (fit1 ? POOL1 : (fit2 ? POOL2 : POOL0));

    off = req_addr - area_base - ADDR_W'(header_bytes);
    in0 = (off >= OFF0) && ((off - OFF0) < ADDR_W'(SPAN0));
    in1 = (off >= OFF1) && ((off - OFF1) < ADDR_W'(SPAN1));
    in2 = (off >= OFF2) && ((off - OFF2) < ADDR_W'(SPAN2));
    free_hit  = in0 | in1 | in2;
    free_pool = in0 ? POOL0 : (in1 ? POOL1 : (in2 ? POOL2 : POOL0));
    diff      = off - off_of(free_pool);
    rel_calc  = diff[REL_W-1:0];
  end

  // Block index from the offset, and the block's byte offset inside its pool.
  always_comb begin
    quot     = quot_of(prod, pool);
    loc_diff = blk - first_of(pool);
    mul_in   = (cmd == CMD_FREE) ? quot : loc_diff[LOC_W-1:0];
    prod2    = REL_W'(mul_in) * bytes_of(pool);
    free_blk = first_of(pool) + BLK_W'(quot);
  end

  always_comb begin
    if (init_ptr == BLK_W'(FIRST1 - 1)) begin
      init_link = '0;
    end else if (init_ptr == BLK_W'(FIRST2 - 1)) begin
      init_link = BLK_W'(FIRST1);
    end else if (init_ptr == BLK_W'(TOTAL_BLOCKS - 1)) begin
      init_link = BLK_W'(FIRST2);
    end else begin
      init_link = init_ptr + BLK_W'(1);
    end
  end

  assign rd_in_use = ram_rd_data[BLK_W];
  assign rd_link   = ram_rd_data[BLK_W-1:0];
  assign out_free  = !m_tvalid || m_tready;
  assign alloc_ok  = (state == S_UPDATE) && out_free && (cmd == CMD_ALLOC) && hit && !exhausted;
  assign free_ok   = (state == S_UPDATE) && out_free && (cmd == CMD_FREE) && hit && aligned &&
                     rd_in_use;

  always_comb begin
    ram_rd_en   = (state == S_INDEX);
    ram_rd_addr = (cmd == CMD_FREE) ? free_blk : blk;
    if (state == S_INIT) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = init_ptr;
      ram_wr_data = {1'b0, init_link};
    end else begin
      ram_wr_en   = alloc_ok || free_ok;
      ram_wr_addr = blk;
      ram_wr_data = alloc_ok ? {1'b1, rd_link} : {1'b0, heads[pool]};
    end
  end

  fbpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL_BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      area_base    <= '0;
      header_bytes <= HEADER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_AREA_BASE:    area_base    <= cfg_data;
        REG_HEADER_BYTES: header_bytes <= cfg_data[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_ptr  <= '0;
      m_tvalid  <= 1'b0;
      heads[0]  <= '0;
      heads[1]  <= BLK_W'(FIRST1);
      heads[2]  <= BLK_W'(FIRST2);
      counts[0] <= CNT_W'(POOL0_COUNT);
      counts[1] <= CNT_W'(POOL1_COUNT);
      counts[2] <= CNT_W'(POOL2_COUNT);
    end else begin
      if (m_tvalid && m_tready && (state != S_UPDATE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (init_ptr == BLK_W'(TOTAL_BLOCKS - 1)) begin
            state <= S_IDLE;
          end else begin
            init_ptr <= init_ptr + BLK_W'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            cmd      <= cmd_t'(s_tuser);
            req_size <= s_tdata[SIZE_W-1:0];
            req_addr <= s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          if (cmd == CMD_FREE) begin
            pool <= free_pool;
            hit  <= free_hit;
          end else begin
            pool <= alloc_pool;
            hit  <= alloc_fit;
          end
          exhausted <= (counts[alloc_pool] == '0);
          blk       <= heads[alloc_pool];
          rel       <= rel_calc;
          prod      <= PROD_W'(rel_calc) * PROD_W'(recip_of(free_pool));
          state     <= S_INDEX;
        end
        S_INDEX: begin
          blk_off <= prod2;
          aligned <= (prod2 == rel);
          if (cmd == CMD_FREE) begin
            blk <= free_blk;
          end
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
            if (!hit) begin
              out_addr   <= '0;
              out_pool   <= POOL0;
              out_status <= (cmd == CMD_FREE) ? STAT_BAD_ADDR : STAT_NO_FIT;
            end else if (cmd == CMD_ALLOC) begin
              out_pool <= pool;
              if (exhausted) begin
                out_addr   <= '0;
                out_status <= STAT_EXHAUSTED;
              end else begin
                out_status    <= STAT_OK;
                out_addr      <= area_base + off_of(pool) + ADDR_W'(blk_off) +
                                 ADDR_W'(header_bytes);
                heads[pool]   <= rd_link;
                counts[pool]  <= counts[pool] - CNT_W'(1);
              end
            end else if (!aligned) begin
              out_addr   <= '0;
              out_pool   <= POOL0;
              out_status <= STAT_BAD_ADDR;
            end else if (!rd_in_use) begin
              out_addr   <= '0;
              out_pool   <= pool;
              out_status <= STAT_ALREADY_FREE;
            end else begin
              out_addr     <= '0;
              out_pool     <= pool;
              out_status   <= STAT_OK;
              heads[pool]  <= blk;
              counts[pool] <= counts[pool] + CNT_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/fbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: sv/fbpa_checker.sv
// Port-level assertions for the fixed block pool allocator and their bind.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [fbpa_pkg::M_TDATA_W-1:0] m_tdata
);

  import fbpa_pkg::*;

  logic [ADDR_W-1:0] res_addr;
  pool_t             res_pool;
  logic [STAT_W-1:0] res_status;

  assign res_addr   = m_tdata[ADDR_W-1:0];
  assign res_pool   = m_tdata[ADDR_W+POOL_W-1:ADDR_W];
  assign res_status = m_tdata[ADDR_W+POOL_W+STAT_W-1:ADDR_W+POOL_W];

  // A stalled result beat keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status != STAT_OK) |-> (res_addr == '0))
    else $error("failed request carries a payload address");

  a_pool_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_status == STAT_NO_FIT || res_status == STAT_BAD_ADDR) |->
    (res_pool == POOL0))
    else $error("unmatched request names a pool");

  a_pool_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_pool != POOL_W'(NUM_POOLS)))
    else $error("pool index out of range");

  // One request at a time: the slave side closes right after a beat.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in flight");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
`default_nettype wire

// File: tb/fbpa_grant_checker.sv
// Result checker for the fixed block pool allocator: predicts every grant and compares it.
`timescale 1ns / 1ps
module fbpa_grant_checker #(
  parameter int unsigned POOL0_BYTES = 16,
  parameter int unsigned POOL0_COUNT = 8,
  parameter int unsigned POOL1_BYTES = 32,
  parameter int unsigned POOL1_COUNT = 8,
  parameter int unsigned POOL2_BYTES = 64,
  parameter int unsigned POOL2_COUNT = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // request_size [15:0], block_address [47:16]
  input  logic [fbpa_pkg::S_TDATA_W-1:0] s_tdata,
  // command [0]
  input  logic [0:0]                     s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // payload_address [31:0], pool_index [33:32], status [36:34], zero fill [39:37]
  input  logic [fbpa_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import fbpa_pkg::*;

  localparam int unsigned BLOCKS = POOL0_COUNT + POOL1_COUNT + POOL2_COUNT;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    pool_t             pool;
    status_t           status;
  } grant_t;

  logic [ADDR_W-1:0] area_base;
  logic [HDR_W-1:0]  header_bytes;
  int unsigned       next_free [BLOCKS];
  int unsigned       list_head [NUM_POOLS];
  int unsigned       list_len  [NUM_POOLS];
  bit                taken     [BLOCKS];
  grant_t            grants_due [$];

  function automatic int unsigned blk_bytes(int p);
    case (p)
      0:       return POOL0_BYTES;
      1:       return POOL1_BYTES;
      default: return POOL2_BYTES;
    endcase
  endfunction

  function automatic int unsigned blk_count(int p);
    case (p)
      0:       return POOL0_COUNT;
      1:       return POOL1_COUNT;
      default: return POOL2_COUNT;
    endcase
  endfunction

  function automatic int unsigned first_blk(int p);
    case (p)
      0:       return 0;
      1:       return POOL0_COUNT;
      default: return POOL0_COUNT + POOL1_COUNT;
    endcase
  endfunction

  function automatic int unsigned pool_start(int p);
    case (p)
      0:       return 0;
      1:       return POOL0_BYTES * POOL0_COUNT;
      default: return POOL0_BYTES * POOL0_COUNT + POOL1_BYTES * POOL1_COUNT;
    endcase
  endfunction

  task automatic restart_pools();
    int unsigned b;
    area_base    = '0;
    header_bytes = HEADER_RESET;
    for (int p = 0; p < NUM_POOLS; p++) begin
      for (int unsigned i = 0; i < blk_count(p); i++) begin
        b            = first_blk(p) + i;
        next_free[b] = (i + 1 < blk_count(p)) ? b + 1 : first_blk(p);
        taken[b]     = 1'b0;
      end
      list_head[p] = first_blk(p);
      list_len[p]  = blk_count(p);
    end
    grants_due.delete();
  endtask

  function automatic grant_t grant_for_alloc(logic [SIZE_W-1:0] size);
    grant_t      g;
    int unsigned need;
    int unsigned b;
    g.addr   = '0;
    g.pool   = POOL0;
    g.status = STAT_NO_FIT;
    need     = size;
    need     = need + header_bytes;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (need <= blk_bytes(p)) begin
        g.pool = pool_t'(p);
        if (list_len[p] == 0) begin
          g.status = STAT_EXHAUSTED;
          return g;
        end
        b = list_head[p];
        if (b >= BLOCKS) begin
          b = 0;
        end
        list_head[p] = next_free[b];
        list_len[p]  = list_len[p] - 1;
        taken[b]     = 1'b1;
        g.addr       = area_base + pool_start(p) + (b - first_blk(p)) * blk_bytes(p)
                       + header_bytes;
        g.status     = STAT_OK;
        return g;
      end
    end
    return g;
  endfunction

  function automatic grant_t grant_for_free(logic [ADDR_W-1:0] addr);
    grant_t            g;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] rel;
    int unsigned       b;
    g.addr   = '0;
    g.pool   = POOL0;
    g.status = STAT_BAD_ADDR;
    off      = addr - area_base - header_bytes;
    for (int p = 0; p < NUM_POOLS; p++) begin
      if (off >= pool_start(p) && off - pool_start(p) < blk_bytes(p) * blk_count(p)) begin
        rel = off - pool_start(p);
        if (rel % blk_bytes(p) != 0) begin
          return g;
        end
        b = first_blk(p) + rel / blk_bytes(p);
        if (b >= BLOCKS) begin
          return g;
        end
        g.pool = pool_t'(p);
        if (!taken[b]) begin
          g.status = STAT_ALREADY_FREE;
          return g;
        end
        next_free[b] = list_head[p];
        list_head[p] = b;
        list_len[p]  = list_len[p] + 1;
        taken[b]     = 1'b0;
        g.status     = STAT_OK;
        return g;
      end
    end
    return g;
  endfunction

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk) begin : watch
    grant_t            want;
    logic [ADDR_W-1:0] got_addr;
    pool_t             got_pool;
    logic [STAT_W-1:0] got_status;
    if (rst) begin
      restart_pools();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_AREA_BASE) begin
          area_base = cfg_data;
        end else begin
          header_bytes = cfg_data[HDR_W-1:0];
        end
      end
      if (m_tvalid && m_tready) begin
        got_addr   = m_tdata[ADDR_W-1:0];
        got_pool   = m_tdata[ADDR_W+POOL_W-1:ADDR_W];
        got_status = m_tdata[ADDR_W+POOL_W+STAT_W-1:ADDR_W+POOL_W];
        if (grants_due.size() == 0) begin
          flag($sformatf("result beat with nothing outstanding: addr %h pool %0d status %0d",
                         got_addr, got_pool, got_status));
        end else begin
          want = grants_due.pop_front();
          if (got_addr !== want.addr || got_pool !== want.pool || got_status !== want.status)
          begin
            flag($sformatf("expected addr %h pool %0d status %0d, got addr %h pool %0d status %0d",
                           want.addr, want.pool, want.status, got_addr, got_pool, got_status));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_ALLOC) begin
          grants_due.push_back(grant_for_alloc(s_tdata[SIZE_W-1:0]));
        end else begin
          grants_due.push_back(grant_for_free(s_tdata[SIZE_W+ADDR_W-1:SIZE_W]));
        end
      end
    end
    pending <= grants_due.size();
  end

endmodule

// File: tb/testbench.sv
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps
module testbench;
  import fbpa_pkg::*;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int QUIET_LIMIT     = 1000;
  localparam int AREA_SPAN       = 640;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
  } request_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [0:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [0:0]           cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data  = '0;
  int                   mismatches;
  int                   pending;

  bit                idle_on      = 1'b1;
  int                stall_left   = 0;
  int                quiet_cycles = 0;
  logic [ADDR_W-1:0] cur_base     = '0;
  logic [HDR_W-1:0]  cur_hdr      = HEADER_RESET;
  logic [ADDR_W-1:0] live_offs  [$];
  logic [ADDR_W-1:0] freed_offs [$];
  request_t          in_flight  [$];
  int                status_hits [5] = '{0, 0, 0, 0, 0};
  int                n_alloc    = 0;
  int                n_free     = 0;
  int                n_results  = 0;
  int                n_settings = 0;

  always #5 clk = ~clk;

  fixed_block_pool_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbpa_grant_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Watchdog: no beat moved on any channel for %0d cycles.", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Keeps track of which blocks the stimulus believes are held, as offsets from the
  // first payload, so that they stay valid across register changes.
  always @(posedge clk) begin : holdings
    request_t          req;
    logic [STAT_W-1:0] st;
    logic [ADDR_W-1:0] rel;
    if (!rst) begin
      if (m_tvalid && m_tready && in_flight.size() > 0) begin
        req = in_flight.pop_front();
        st  = m_tdata[ADDR_W+POOL_W+STAT_W-1:ADDR_W+POOL_W];
        n_results++;
        if (st < 5) begin
          status_hits[st]++;
        end
        if (st == STAT_OK) begin
          if (req.cmd == CMD_ALLOC) begin
            live_offs.push_back(m_tdata[ADDR_W-1:0] - cur_base - cur_hdr);
          end else begin
            rel = req.addr - cur_base - cur_hdr;
            for (int i = 0; i < live_offs.size(); i++) begin
              if (live_offs[i] == rel) begin
                live_offs.delete(i);
                break;
              end
            end
            freed_offs.push_back(rel);
            if (freed_offs.size() > 8) begin
              void'(freed_offs.pop_front());
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        req.cmd  = cmd_t'(s_tuser);
        req.addr = s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
        in_flight.push_back(req);
        if (req.cmd == CMD_ALLOC) begin
          n_alloc++;
        end else begin
          n_free++;
        end
      end
    end
  end

  function automatic logic [ADDR_W-1:0] block_offset(int p, int i);
    case (p)
      0:       return 16 * i;
      1:       return 128 + 32 * i;
      default: return 384 + 64 * i;
    endcase
  endfunction

  task automatic push_request(cmd_t cmd, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {addr, size};
    do @(posedge clk); while (!s_tready);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic ask_alloc(logic [SIZE_W-1:0] size);
    push_request(CMD_ALLOC, size, $urandom);
  endtask

  task automatic give_back(logic [ADDR_W-1:0] addr);
    push_request(CMD_FREE, SIZE_W'($urandom_range(0, 65535)), addr);
  endtask

  task automatic write_config(logic [ADDR_W-1:0] base, logic [HDR_W-1:0] hdr);
    logic [ADDR_W-1:0] junk;
    junk      = $urandom;
    cfg_valid <= 1'b1;
    cfg_index <= REG_AREA_BASE;
    cfg_data  <= base;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_HEADER_BYTES;
    cfg_data  <= {junk[ADDR_W-1:HDR_W], hdr};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_base  = base;
    cur_hdr   = hdr;
    n_settings++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_request();
    int                pick;
    int                p;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] rel;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 9))
        6:       size = SIZE_W'((16 << $urandom_range(0, 2)) - cur_hdr);
        7:       size = SIZE_W'((16 << $urandom_range(0, 2)) - cur_hdr + 1);
        8:       size = SIZE_W'($urandom_range(0, 65535));
        9:       size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default: size = SIZE_W'($urandom_range(0, 70));
      endcase
      ask_alloc(size);
    end else if (pick < 85 && live_offs.size() > 0) begin
      give_back(cur_base + cur_hdr + live_offs[$urandom_range(0, live_offs.size() - 1)]);
    end else if (pick < 93) begin
      if ($urandom_range(0, 1) == 1 && freed_offs.size() > 0) begin
        rel = freed_offs[$urandom_range(0, freed_offs.size() - 1)];
      end else begin
        p   = $urandom_range(0, 2);
        rel = block_offset(p, $urandom_range(0, (p == 2) ? 3 : 7));
      end
      give_back(cur_base + cur_hdr + rel);
    end else begin
      p = $urandom_range(0, 2);
      case ($urandom_range(0, 3))
        0: addr = $urandom;
        1: addr = cur_base + cur_hdr + block_offset(p, $urandom_range(0, 3))
                  + $urandom_range(1, 15);
        2: addr = cur_base + cur_hdr + AREA_SPAN + 16 * $urandom_range(0, 3);
        default: addr = cur_base + cur_hdr - 16 * $urandom_range(1, 4);
      endcase
      give_back(addr);
    end
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0] phase_base [PHASES];
    logic [HDR_W-1:0]  phase_hdr  [PHASES];
    phase_base[0] = 32'h0000_1000;  phase_hdr[0] = 4'd8;
    phase_base[1] = 32'hFFFF_FF80;  phase_hdr[1] = 4'd15;
    phase_base[2] = 32'h0000_0000;  phase_hdr[2] = 4'd0;
    phase_base[3] = 32'hFFFF_FFFF;  phase_hdr[3] = 4'd15;
    phase_base[4] = $urandom;       phase_hdr[4] = HDR_W'($urandom_range(0, 15));
    phase_base[5] = 32'h8000_0000;  phase_hdr[5] = 4'd1;
    phase_base[6] = $urandom;       phase_hdr[6] = 4'd4;
    phase_base[7] = $urandom;       phase_hdr[7] = HDR_W'($urandom_range(0, 15));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_config(32'h0000_0000, HEADER_RESET);

    // Size boundaries of each pool, no fit, and running the largest pool dry.
    ask_alloc(16'd0);
    ask_alloc(16'd8);
    ask_alloc(16'd9);
    ask_alloc(16'd24);
    ask_alloc(16'd25);
    ask_alloc(16'd56);
    ask_alloc(16'd57);
    ask_alloc(16'hFFFF);
    ask_alloc(16'd40);
    ask_alloc(16'd33);
    ask_alloc(16'd56);
    // Good free, double free, misaligned, out of range and never allocated blocks.
    give_back(32'd8);
    give_back(32'd8);
    give_back(32'd9);
    give_back(32'd400);
    give_back(32'hFFFF_FFFF);
    give_back(32'd648);
    give_back(32'd360);
    give_back(32'd392);
    ask_alloc(16'd1);
    ask_alloc(16'd50);
    give_back(32'd0);
    give_back(32'd24);

    // Blocks still held carry over each register change.
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_config(phase_base[ph], phase_hdr[ph]);
      idle_on = (ph != PHASES - 1);
      repeat (ITEMS_PER_PHASE) random_request();
    end
    settle();
    repeat (8) @(posedge clk);

    $display("Checked %0d results for %0d allocate and %0d free requests over %0d settings.",
             n_results, n_alloc, n_free, n_settings);
    $display("Status mix: ok %0d, exhausted %0d, no fit %0d, bad address %0d, already free %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
